// ===== hw/rtl/rlbd_pkg.sv =====
// Shared types and constants for the run-length bitmap decoder.
`default_nettype none
package rlbd_pkg;

  localparam int ROWB_W = 20;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic       text_end;
    logic [3:0] row_select;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        cells_written;
    logic [ROWB_W-1:0] row_bits;
  } out_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    PH_KIND,
    PH_FIRST,
    PH_DIGITS,
    PH_ERROR
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROW_WAIT,
    S_APPLY_RD,
    S_APPLY_WR,
    S_DONE
  } state_t;

  localparam logic [2:0] ST_CONSUMED       = 3'd0;
  localparam logic [2:0] ST_APPLIED        = 3'd1;
  localparam logic [2:0] ST_OVERFLOW       = 3'd2;
  localparam logic [2:0] ST_PARSE_ERR      = 3'd3;
  localparam logic [2:0] ST_END_INCOMPLETE = 3'd4;
  localparam logic [2:0] ST_END_COMPLETE   = 3'd5;
  localparam logic [2:0] ST_ROW_READ       = 3'd6;
  localparam logic [2:0] ST_IGNORED        = 3'd7;

  localparam logic [7:0] CHAR_WALL = 8'h77;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [8:0] COUNT_MAX = 9'd511;

endpackage
`default_nettype wire

// ===== hw/rtl/rlbd_bitmap_mem.sv =====
// Bitmap row memory with per-row valid bits and registered read data.
`default_nettype none
module rlbd_bitmap_mem #(
  parameter int MAP_COLS = 20,
  parameter int MAP_ROWS = 12,
  localparam int ADDR_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rlbd_pkg::mem_ctl_t    ctl,
  input  logic [ADDR_W-1:0]     addr,
  input  logic [MAP_COLS-1:0]   wdata,
  output logic [MAP_COLS-1:0]   rdata
);
  import rlbd_pkg::*;

  logic [MAP_COLS-1:0] mem_r [MAP_ROWS];
  logic [MAP_ROWS-1:0] vld_r;
  logic [MAP_COLS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= vld_r[addr] ? mem_r[addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[addr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/rlbd_seq.sv =====
// Parser and section sequencer: row read-modify-write of the bitmap memory.
`default_nettype none
module rlbd_seq #(
  parameter int MAP_COLS = 20,
  parameter int MAP_ROWS = 12,
  localparam int ADDR_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rlbd_pkg::in_t         in_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output rlbd_pkg::out_t        res,
  output rlbd_pkg::mem_ctl_t    mem_ctl,
  output logic [ADDR_W-1:0]     mem_addr,
  output logic [MAP_COLS-1:0]   mem_wdata,
  input  logic [MAP_COLS-1:0]   mem_rdata
);
  import rlbd_pkg::*;

  localparam int COL_W = $clog2(MAP_COLS + 1);
  localparam int ROW_W = $clog2(MAP_ROWS + 1);

  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic                wall_r, wall_nxt;
  logic [8:0]          cnt_r, cnt_nxt;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [8:0]          rem_r, rem_nxt;
  logic                end_r, end_nxt;
  logic                kind_r, kind_nxt;
  logic                kindw_r, kindw_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  out_t                res_r, res_nxt;

  logic                acc;
  logic                digit;
  logic                is_w;
  logic [12:0]         acc_sum;
  logic [8:0]          cnt_sat;
  phase_t              ph_c;
  logic [8:0]          cnt_c;
  logic                wall_c;
  logic [2:0]          st_c;
  logic                apply_req;
  logic [15:0]         cells_full;
  logic [7:0]          cells;
  logic                row_full;
  logic                apply_done;
  logic                ovf;
  logic [COL_W-1:0]    avail;
  logic [COL_W-1:0]    k;
  logic [COL_W-1:0]    end_pos;
  logic [MAP_COLS-1:0] mask;
  logic                sel_ok;
  logic [ADDR_W+3:0]   sel_ext;
  logic [MAP_COLS+ROWB_W-1:0] rd_ext;

  assign acc        = in_valid && (state_r == S_IDLE);
  assign is_w       = (in_data.char_code == CHAR_WALL);
  assign digit      = (in_data.char_code >= CHAR_ZERO) && (in_data.char_code <= CHAR_NINE);
  assign acc_sum    = (13'(cnt_r) << 3) + (13'(cnt_r) << 1) + 13'(in_data.char_code[3:0]);
  assign cnt_sat    = (acc_sum > 13'(COUNT_MAX)) ? COUNT_MAX : acc_sum[8:0];
  assign cells_full = 16'(row_r) * 16'(MAP_COLS) + 16'(col_r);
  assign cells      = cells_full[7:0];
  assign row_full   = (row_r >= ROW_W'(MAP_ROWS));
  assign apply_done = (rem_r == '0) || row_full;
  assign ovf        = (rem_r != '0);
  assign sel_ok     = (7'(in_data.row_select) < 7'(MAP_ROWS));
  assign sel_ext    = {{ADDR_W{1'b0}}, in_data.row_select};
  assign rd_ext     = {{ROWB_W{1'b0}}, mem_rdata};

  // character step of the parser
  always_comb begin
    ph_c   = phase_r;
    cnt_c  = cnt_r;
    wall_c = wall_r;
    st_c   = ST_CONSUMED;
    unique case (phase_r)
      PH_KIND: begin
        ph_c   = PH_FIRST;
        wall_c = is_w;
        cnt_c  = '0;
      end
      PH_FIRST: begin
        if (digit) begin
          ph_c  = PH_DIGITS;
          cnt_c = 9'(in_data.char_code[3:0]);
        end else begin
          ph_c = PH_ERROR;
          st_c = ST_PARSE_ERR;
        end
      end
      PH_DIGITS: begin
        if (digit) begin
          cnt_c = cnt_sat;
        end
      end
      PH_ERROR: begin
        st_c = ST_IGNORED;
      end
      default: begin
        st_c = ST_IGNORED;
      end
    endcase
  end

  assign apply_req = ((phase_r == PH_DIGITS) && !digit) ||
                     ((ph_c == PH_DIGITS) && in_data.text_end);

  // span of the section within the current row
  always_comb begin
    avail   = COL_W'(MAP_COLS) - col_r;
    k       = (9'(avail) <= rem_r) ? avail : rem_r[COL_W-1:0];
    end_pos = col_r + k;
    for (int i = 0; i < MAP_COLS; i++) begin
      mask[i] = (COL_W'(i) >= col_r) && (COL_W'(i) < end_pos);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.mode) begin
            state_nxt = S_ROW_WAIT;
          end else if (apply_req) begin
            state_nxt = S_APPLY_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_ROW_WAIT: state_nxt = S_DONE;
      S_APPLY_RD: state_nxt = apply_done ? S_DONE : S_APPLY_WR;
      S_APPLY_WR: state_nxt = S_APPLY_RD;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall      = (state_r != S_IDLE);
    res_valid     = (state_r == S_DONE);
    mem_ctl.rd_en = 1'b0;
    mem_ctl.wr_en = 1'b0;
    mem_addr      = row_r[ADDR_W-1:0];
    mem_wdata     = wall_r ? (mem_rdata | mask) : (mem_rdata & ~mask);
    unique case (state_r)
      S_IDLE: begin
        mem_addr      = sel_ext[ADDR_W-1:0];
        mem_ctl.rd_en = acc && in_data.mode && sel_ok;
      end
      S_APPLY_RD: mem_ctl.rd_en = !apply_done;
      S_APPLY_WR: mem_ctl.wr_en = 1'b1;
      S_ROW_WAIT, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    phase_nxt = phase_r;
    wall_nxt  = wall_r;
    cnt_nxt   = cnt_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    rem_nxt   = rem_r;
    end_nxt   = end_r;
    kind_nxt  = kind_r;
    kindw_nxt = kindw_r;
    rd_ok_nxt = rd_ok_r;
    res_nxt   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_data.mode) begin
            rd_ok_nxt = sel_ok;
          end else if (apply_req) begin
            phase_nxt = ph_c;
            cnt_nxt   = cnt_c;
            rem_nxt   = cnt_c;
            end_nxt   = in_data.text_end;
            kind_nxt  = !digit;
            kindw_nxt = is_w;
          end else begin
            res_nxt.cells_written = cells;
            res_nxt.row_bits      = '0;
            if (in_data.text_end) begin
              res_nxt.status = ST_END_INCOMPLETE;
              phase_nxt      = PH_KIND;
              wall_nxt       = 1'b0;
              cnt_nxt        = '0;
              col_nxt        = '0;
              row_nxt        = '0;
            end else begin
              res_nxt.status = st_c;
              phase_nxt      = ph_c;
              wall_nxt       = wall_c;
              cnt_nxt        = cnt_c;
            end
          end
        end
      end
      S_ROW_WAIT: begin
        res_nxt.status        = ST_ROW_READ;
        res_nxt.cells_written = cells;
        res_nxt.row_bits      = rd_ok_r ? rd_ext[ROWB_W-1:0] : '0;
      end
      S_APPLY_RD: begin
        if (apply_done) begin
          res_nxt.cells_written = cells;
          res_nxt.row_bits      = '0;
          if (end_r) begin
            res_nxt.status = (!ovf && !kind_r && row_full) ? ST_END_COMPLETE
                                                           : ST_END_INCOMPLETE;
            phase_nxt      = PH_KIND;
            wall_nxt       = 1'b0;
            cnt_nxt        = '0;
            col_nxt        = '0;
            row_nxt        = '0;
          end else if (ovf) begin
            res_nxt.status = ST_OVERFLOW;
            phase_nxt      = PH_ERROR;
          end else begin
            res_nxt.status = ST_APPLIED;
            phase_nxt      = PH_FIRST;
            wall_nxt       = kindw_r;
            cnt_nxt        = '0;
          end
        end
      end
      S_APPLY_WR: begin
        rem_nxt = rem_r - 9'(k);
        if (end_pos == COL_W'(MAP_COLS)) begin
          col_nxt = '0;
          row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = end_pos;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_KIND;
      wall_r  <= 1'b0;
      cnt_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      rem_r   <= '0;
      end_r   <= 1'b0;
      kind_r  <= 1'b0;
      kindw_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      wall_r  <= wall_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      rem_r   <= rem_nxt;
      end_r   <= end_nxt;
      kind_r  <= kind_nxt;
      kindw_r <= kindw_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== hw/rtl/run_length_bitmap_decoder_top.sv =====
// Top level of the run-length bitmap decoder: sequencer, bitmap memory, output register.
//
// Input channel (in_valid/in_stall/in_data): one transaction per text character
// (mode 0) or per bitmap row read (mode 1). Output channel (out_valid/out_stall/
// out_data): exactly one result transaction per input transaction, in order.
// A transaction moves at a rising edge with valid high and stall low.
// A character that does not close a section goes to S_DONE, and its result then
// moves from the sequencer's result register into the output register; a row read
// passes through S_ROW_WAIT first, for the registered memory read data. A character
// that closes a section first runs a read-modify-write of every bitmap row the
// section touches, one row at a time through the single memory port (S_APPLY_RD,
// then S_APPLY_WR), up to MAP_ROWS rows; no input is taken before S_IDLE again.
// The output register holds one result; a new input is taken while it waits,
// and the sequencer holds its finished result until out_stall releases the slot.
// Reset (rst_n low, synchronous) clears the parser, cursor, channel state and
// the row valid bits, so the bitmap reads as all zeros; no clearing pass.
`default_nettype none
module run_length_bitmap_decoder_top #(
  parameter int MAP_COLS = 20,
  parameter int MAP_ROWS = 12
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  rlbd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output rlbd_pkg::out_t out_data
);
  import rlbd_pkg::*;

  localparam int ADDR_W = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;

  logic                res_valid;
  logic                res_ready;
  out_t                seq_res;
  mem_ctl_t            mem_ctl;
  logic [ADDR_W-1:0]   mem_addr;
  logic [MAP_COLS-1:0] mem_wdata;
  logic [MAP_COLS-1:0] mem_rdata;
  logic                out_valid_r;
  out_t                out_data_r;

  rlbd_seq #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (seq_res),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  rlbd_bitmap_mem #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= seq_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in progress");

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (out_valid_r && (out_data_r == $past(seq_res))))
    else $error("finished result not moved into the output register");

  a_mem_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.rd_en && mem_ctl.wr_en))
    else $error("memory read and write in the same cycle");

  a_mem_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.rd_en || mem_ctl.wr_en) |-> (int'(mem_addr) < MAP_ROWS))
    else $error("memory access beyond the last row");

endmodule
`default_nettype wire
